### hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types, widths and the divider step for the segment intersection test.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int CoordW  = 16;
    localparam int DiffW   = CoordW + 1;        // exact coordinate difference
    localparam int ProdW   = 2 * DiffW;         // one cross-product term
    localparam int DenW    = ProdW - 1;         // |den| after sign fix
    localparam int NumW    = DenW + CoordW;     // |tn * s1| magnitude
    localparam int QuotW   = CoordW;            // |quotient| <= 65535
    localparam int FifoDepth = 4;
    localparam int FifoAw  = $clog2(FifoDepth);

    // One classified request handed from the front end to the divider.
    typedef struct packed {
        logic              hit;
        logic [CoordW-1:0] ax0;
        logic [CoordW-1:0] ay0;
        logic [DenW-1:0]   den;
        logic [NumW-1:0]   num_x;
        logic              neg_x;
        logic [NumW-1:0]   num_y;
        logic              neg_y;
    } sit_entry_t;

    // One slot of the divider pipeline.
    typedef struct packed {
        logic              hit;
        logic [CoordW-1:0] ax0;
        logic [CoordW-1:0] ay0;
        logic [DenW-1:0]   den;
        logic [NumW-1:0]   rem_x;
        logic [QuotW-1:0]  quo_x;
        logic              neg_x;
        logic [NumW-1:0]   rem_y;
        logic [QuotW-1:0]  quo_y;
        logic              neg_y;
    } sit_div_t;

    // One restoring step: compare against den shifted by k, subtract on fit.
    // Returns {quotient bit, new remainder}.
    function automatic logic [NumW:0] div_step(input logic [NumW-1:0] rem,
                                               input logic [DenW-1:0] den,
                                               input int k);
        logic [NumW:0] sh;
        logic [NumW:0] r;
        sh = {{(NumW+1-DenW){1'b0}}, den} << k;
        r  = {1'b0, rem};
        if (r >= sh) begin
            r = r - sh;
            return {1'b1, r[NumW-1:0]};
        end
        return {1'b0, r[NumW-1:0]};
    endfunction

endpackage

### hw/rtl/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Forms differences, cross products, the hit decision and the two division
// numerators in five pipeline stages.
// ----------------------------------------------------------------------------
module sit_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [8*sit_pkg::CoordW-1:0] in_data,
    output logic                         push,
    input  logic                         q_full,
    output sit_pkg::sit_entry_t          push_entry
);
    import sit_pkg::*;

    logic [4:0] vld_reg, vld_next;
    logic       en;

    logic [CoordW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

    // stage 1
    logic signed [DiffW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, ox_reg, oy_reg;
    logic [CoordW-1:0]       ax0_1_reg, ay0_1_reg;
    // stage 2
    logic signed [ProdW-1:0] p_a_reg, p_b_reg, p_c_reg, p_d_reg, p_e_reg, p_f_reg;
    logic signed [DiffW-1:0] d1x_2_reg, d1y_2_reg;
    logic [CoordW-1:0]       ax0_2_reg, ay0_2_reg;
    // stage 3
    logic signed [ProdW:0]   den_reg, sn_reg, tn_reg;
    logic signed [DiffW-1:0] d1x_3_reg, d1y_3_reg;
    logic [CoordW-1:0]       ax0_3_reg, ay0_3_reg;
    // stage 4
    logic                    hit_reg;
    logic [DenW-1:0]         den_u_reg, tn_u_reg;
    logic [QuotW-1:0]        mx_reg, my_reg;
    logic                    nx_reg, ny_reg;
    logic [CoordW-1:0]       ax0_4_reg, ay0_4_reg;
    // stage 5
    sit_entry_t              out_reg;

    logic signed [ProdW:0]   den_a, sn_a, tn_a;
    logic                    flip, hit_next;
    logic signed [DiffW-1:0] d1x_neg, d1y_neg;

    assign {by1, bx1, by0, bx0, ay1, ax1, ay0, ax0} = in_data;

    assign en       = !(vld_reg[4] && q_full);
    assign in_ready = en;
    assign push     = vld_reg[4] && !q_full;
    assign push_entry = out_reg;

    assign vld_next = {vld_reg[3:0], in_valid};

    always_comb begin
        flip    = den_reg[ProdW];
        den_a   = flip ? -den_reg : den_reg;
        sn_a    = flip ? -sn_reg  : sn_reg;
        tn_a    = flip ? -tn_reg  : tn_reg;
        hit_next = (den_a != '0) && !sn_a[ProdW] && (sn_a <= den_a)
                   && !tn_a[ProdW] && (tn_a <= den_a);
        d1x_neg = -d1x_3_reg;
        d1y_neg = -d1y_3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1x_reg   <= $signed({ax1[CoordW-1], ax1}) - $signed({ax0[CoordW-1], ax0});
            d1y_reg   <= $signed({ay1[CoordW-1], ay1}) - $signed({ay0[CoordW-1], ay0});
            d2x_reg   <= $signed({bx1[CoordW-1], bx1}) - $signed({bx0[CoordW-1], bx0});
            d2y_reg   <= $signed({by1[CoordW-1], by1}) - $signed({by0[CoordW-1], by0});
            ox_reg    <= $signed({ax0[CoordW-1], ax0}) - $signed({bx0[CoordW-1], bx0});
            oy_reg    <= $signed({ay0[CoordW-1], ay0}) - $signed({by0[CoordW-1], by0});
            ax0_1_reg <= ax0;
            ay0_1_reg <= ay0;

            p_a_reg   <= d1x_reg * d2y_reg;
            p_b_reg   <= d2x_reg * d1y_reg;
            p_c_reg   <= d1x_reg * oy_reg;
            p_d_reg   <= d1y_reg * ox_reg;
            p_e_reg   <= d2x_reg * oy_reg;
            p_f_reg   <= d2y_reg * ox_reg;
            d1x_2_reg <= d1x_reg;
            d1y_2_reg <= d1y_reg;
            ax0_2_reg <= ax0_1_reg;
            ay0_2_reg <= ay0_1_reg;

            den_reg   <= $signed({p_a_reg[ProdW-1], p_a_reg})
                         - $signed({p_b_reg[ProdW-1], p_b_reg});
            sn_reg    <= $signed({p_c_reg[ProdW-1], p_c_reg})
                         - $signed({p_d_reg[ProdW-1], p_d_reg});
            tn_reg    <= $signed({p_e_reg[ProdW-1], p_e_reg})
                         - $signed({p_f_reg[ProdW-1], p_f_reg});
            d1x_3_reg <= d1x_2_reg;
            d1y_3_reg <= d1y_2_reg;
            ax0_3_reg <= ax0_2_reg;
            ay0_3_reg <= ay0_2_reg;

            // normalize so den is positive, then range-check both parameters
            hit_reg   <= hit_next;
            den_u_reg <= den_a[DenW-1:0];
            tn_u_reg  <= tn_a[DenW-1:0];
            nx_reg    <= d1x_3_reg[DiffW-1];
            ny_reg    <= d1y_3_reg[DiffW-1];
            mx_reg    <= d1x_3_reg[DiffW-1] ? d1x_neg[QuotW-1:0] : d1x_3_reg[QuotW-1:0];
            my_reg    <= d1y_3_reg[DiffW-1] ? d1y_neg[QuotW-1:0] : d1y_3_reg[QuotW-1:0];
            ax0_4_reg <= ax0_3_reg;
            ay0_4_reg <= ay0_3_reg;

            out_reg.hit   <= hit_reg;
            out_reg.ax0   <= ax0_4_reg;
            out_reg.ay0   <= ay0_4_reg;
            out_reg.den   <= den_u_reg;
            out_reg.num_x <= tn_u_reg * mx_reg;
            out_reg.neg_x <= nx_reg;
            out_reg.num_y <= tn_u_reg * my_reg;
            out_reg.neg_y <= ny_reg;
        end
    end

endmodule

### hw/rtl/sit_fifo.sv
// ----------------------------------------------------------------------------
// sit_fifo
// Short queue between the classifier front end and the divider back end.
// ----------------------------------------------------------------------------
module sit_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sit_pkg::sit_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output sit_pkg::sit_entry_t pop_entry
);
    import sit_pkg::*;

    sit_entry_t          mem_reg [FifoDepth];
    logic [FifoAw-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [FifoAw:0]     cnt_reg, cnt_next;

    assign full      = (cnt_reg == (FifoAw+1)'(FifoDepth));
    assign empty     = (cnt_reg == '0);
    assign pop_entry = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/sit_back.sv
// ----------------------------------------------------------------------------
// sit_back
// Pipelined restoring divider, one quotient bit per stage for x and y, then
// floor correction, offset add and the output register.
// ----------------------------------------------------------------------------
module sit_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    output logic                pop,
    input  sit_pkg::sit_entry_t pop_entry,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_hit,
    output logic [sit_pkg::CoordW-1:0] out_x,
    output logic [sit_pkg::CoordW-1:0] out_y
);
    import sit_pkg::*;

    sit_div_t          st_reg  [QuotW+1];
    sit_div_t          st_next [QuotW+1];
    logic [QuotW:0]    vld_reg;
    logic              en;
    logic              ov_reg;
    logic              hit_reg;
    logic [CoordW-1:0] x_reg, y_reg;

    sit_div_t          last;
    logic [NumW:0]     sx, sy;
    logic [QuotW:0]    qc_x, qc_y, sq_x, sq_y;
    logic [CoordW-1:0] px, py;

    assign en  = !ov_reg || out_ready;
    assign pop = en && !q_empty;

    always_comb begin
        st_next[0].hit   = pop_entry.hit;
        st_next[0].ax0   = pop_entry.ax0;
        st_next[0].ay0   = pop_entry.ay0;
        st_next[0].den   = pop_entry.den;
        st_next[0].rem_x = pop_entry.num_x;
        st_next[0].quo_x = '0;
        st_next[0].neg_x = pop_entry.neg_x;
        st_next[0].rem_y = pop_entry.num_y;
        st_next[0].quo_y = '0;
        st_next[0].neg_y = pop_entry.neg_y;
        sx = '0;
        sy = '0;
        for (int j = 0; j < QuotW; j++) begin
            sx = div_step(st_reg[j].rem_x, st_reg[j].den, QuotW-1-j);
            sy = div_step(st_reg[j].rem_y, st_reg[j].den, QuotW-1-j);
            st_next[j+1]       = st_reg[j];
            st_next[j+1].rem_x = sx[NumW-1:0];
            st_next[j+1].rem_y = sy[NumW-1:0];
            st_next[j+1].quo_x[QuotW-1-j] = sx[NumW];
            st_next[j+1].quo_y[QuotW-1-j] = sy[NumW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    // floor toward minus infinity: bump magnitude when negative and inexact
    always_comb begin
        last = st_reg[QuotW];
        qc_x = {1'b0, last.quo_x} + (QuotW+1)'(last.neg_x && (last.rem_x != '0));
        qc_y = {1'b0, last.quo_y} + (QuotW+1)'(last.neg_y && (last.rem_y != '0));
        sq_x = last.neg_x ? -qc_x : qc_x;
        sq_y = last.neg_y ? -qc_y : qc_y;
        px   = last.ax0 + sq_x[CoordW-1:0];
        py   = last.ay0 + sq_y[CoordW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[QuotW-1:0], !q_empty};
            ov_reg  <= vld_reg[QuotW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= last.hit;
            x_reg   <= last.hit ? px : '0;
            y_reg   <= last.hit ? py : '0;
        end
    end

    assign out_valid = ov_reg;
    assign out_hit   = hit_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

### hw/rtl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test
// Parametric 2-D segment intersection in signed Q12.4 with floored crossing.
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle and returns one result per pair, in order.
// The result follows the input handshake through five front-end stages
// (differences, cross products, numerators and denominator, sign fix and
// range check, numerator multiply), a four-entry queue, the divider input
// register, sixteen restoring-divider stages (one quotient bit each, x and y
// side by side) and the output register. Sustained rate is one pair per
// cycle while m_tready stays high; the queue lets the front end keep
// accepting while the divider is stalled until it fills.
// Parallel or collinear pairs report no hit; on no hit the point is zero.
module segment_intersection_test (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (16 bits each, from bit 0 up)
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cross_x [15:0], cross_y [31:16]
    output logic [31:0]  m_tdata,
    // hit
    output logic [0:0]   m_tuser
);
    import sit_pkg::*;

    logic       push, pop, q_full, q_empty;
    sit_entry_t push_entry, pop_entry;
    logic [CoordW-1:0] cx, cy;
    logic       hit;

    sit_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .push       (push),
        .q_full     (q_full),
        .push_entry (push_entry)
    );

    sit_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .pop_entry  (pop_entry)
    );

    sit_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .pop       (pop),
        .pop_entry (pop_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (hit),
        .out_x     (cx),
        .out_y     (cy)
    );

    assign m_tdata = {cy, cx};
    assign m_tuser = hit;

endmodule
